@@ sv/gcs_pkg.sv @@
// gcs_pkg: widths, constants and shared types of the curvature stencil
// used by gcs_front, gcs_queue, gcs_back and gradient_curvature_stencil
// no dependencies
package gcs_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int INNER_BITS    = 16;
    localparam int PIX_W         = 18;
    localparam int OUT_W         = 24;
    localparam int THR_W         = 16;
    localparam int NUM_PIX       = 9;
    localparam int CFG_ADDR_W    = 4;

    // shift from pixel format to the q16 inner format
    localparam int SHIFT = INNER_BITS - FRACTION_BITS;
    localparam int PW    = PIX_W + SHIFT;  // one pixel in q16
    localparam int SW    = PW + 1;         // sum of two pixels
    localparam int AXW   = PW + 2;         // ax, ay
    localparam int LW    = PW + 2;         // isotropic curvature
    localparam int TW    = PW + 3;         // offset laplacian for the divide by 3

    localparam logic [17:0] SQRT2_Q16 = 18'd92682;
    localparam logic [17:0] CONS_Q16  = 18'd19195;

    localparam logic [THR_W-1:0] THR_RESET = 16'd256;

    // register indexes
    localparam logic [1:0] REG_GRAD_THRESHOLD = 2'd0;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [AXW-1:0] ax;
        logic signed [AXW-1:0] ay;
        logic signed [LW-1:0]  lap;
        logic signed [SW-1:0]  ce;
        logic signed [SW-1:0]  lr;
        logic signed [SW-1:0]  ud;
        logic signed [SW-1:0]  dru;
        logic signed [SW-1:0]  dlu;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ sv/gcs_front.sv @@
// gcs_front: input register, gradients and isotropic laplacian in four stages
// depends on gcs_pkg
module gcs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [gcs_pkg::PIX_W-1:0]   i_pix [gcs_pkg::NUM_PIX],
    output logic                               o_valid,
    output gcs_pkg::t_qent                     o_ent
);
    import gcs_pkg::*;

    localparam int IX_UL = 0;
    localparam int IX_UP = 1;
    localparam int IX_UR = 2;
    localparam int IX_LF = 3;
    localparam int IX_CE = 4;
    localparam int IX_RT = 5;
    localparam int IX_DL = 6;
    localparam int IX_DN = 7;
    localparam int IX_DR = 8;
    localparam int SX    = PW + 5;
    localparam logic [TW-1:0] LAP_OFF = TW'(3) << PW;
    localparam logic [TW:0]   DIV3_M  = (TW + 1)'(((64'd1 << (TW + 2)) + 64'd2) / 64'd3);

    logic [3:0] r_v;

    // stage 0
    logic signed [PIX_W-1:0] r_pix [NUM_PIX];

    // stage 1
    logic signed [PW+1:0] r1_cmd, r1_cpd;
    logic signed [PW:0]   r1_rl, r1_du;
    logic [TW-1:0]        r1_t;
    logic signed [SW-1:0] r1_ce, r1_lr, r1_ud, r1_dru, r1_dlu;

    // stage 2
    logic signed [PW+3:0] r2_px, r2_py;
    logic signed [PW:0]   r2_rl, r2_du;
    logic [PW+1:0]        r2_lapq;
    logic signed [SW-1:0] r2_ce, r2_lr, r2_ud, r2_dru, r2_dlu;

    // stage 3
    t_qent r3;

    logic signed [PW-1:0]  w_q [NUM_PIX];
    logic signed [PW:0]    w_c1, w_d1;
    logic signed [SX-1:0]  w_s;
    logic signed [TW-1:0]  w_s4;
    logic signed [PW+19:0] w_mx, w_my;
    logic [2*TW:0]         w_md;
    logic signed [PW+3:0]  w_sx, w_sy;
    logic signed [PW+21:0] w_ax, w_ay;
    logic signed [PW+2:0]  w_lap;

    always_comb begin
        for (int i = 0; i < NUM_PIX; i++) begin
            w_q[i] = PW'(r_pix[i]) <<< SHIFT;
        end
        w_c1 = (PW + 1)'(w_q[IX_DR]) - (PW + 1)'(w_q[IX_UL]);
        w_d1 = (PW + 1)'(w_q[IX_DL]) - (PW + 1)'(w_q[IX_UR]);
        w_s  = SX'(w_q[IX_UL]) + SX'(w_q[IX_UR]) + SX'(w_q[IX_DL]) + SX'(w_q[IX_DR])
             + ((SX'(w_q[IX_UP]) + SX'(w_q[IX_LF]) + SX'(w_q[IX_RT]) + SX'(w_q[IX_DN])) <<< 1)
             - (SX'(w_q[IX_CE]) <<< 3) - (SX'(w_q[IX_CE]) <<< 2);
        // floor(s/12) = floor(floor(s/4)/3), offset keeps the dividend positive
        w_s4 = TW'(w_s >>> 2);
        w_mx = $signed(SQRT2_Q16) * r1_cmd;
        w_my = $signed(SQRT2_Q16) * r1_cpd;
        w_md = (2 * TW + 1)'(r1_t) * (2 * TW + 1)'(DIV3_M);
        w_sx = (PW + 4)'(r2_rl) + r2_px;
        w_sy = (PW + 4)'(r2_du) + r2_py;
        w_ax = $signed(CONS_Q16) * w_sx;
        w_ay = $signed(CONS_Q16) * w_sy;
        w_lap = $signed({1'b0, r2_lapq}) - $signed((PW + 3)'(1) << PW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix  <= i_pix;

            r1_cmd <= (PW + 2)'(w_c1) - (PW + 2)'(w_d1);
            r1_cpd <= (PW + 2)'(w_c1) + (PW + 2)'(w_d1);
            r1_rl  <= (PW + 1)'(w_q[IX_RT]) - (PW + 1)'(w_q[IX_LF]);
            r1_du  <= (PW + 1)'(w_q[IX_DN]) - (PW + 1)'(w_q[IX_UP]);
            r1_t   <= w_s4 + LAP_OFF;
            r1_ce  <= SW'(w_q[IX_CE]);
            r1_lr  <= SW'(w_q[IX_LF]) + SW'(w_q[IX_RT]);
            r1_ud  <= SW'(w_q[IX_UP]) + SW'(w_q[IX_DN]);
            r1_dru <= SW'(w_q[IX_DR]) + SW'(w_q[IX_UL]);
            r1_dlu <= SW'(w_q[IX_DL]) + SW'(w_q[IX_UR]);

            r2_px   <= w_mx[PW+19:16];
            r2_py   <= w_my[PW+19:16];
            r2_lapq <= w_md[2*TW:TW+2];
            r2_rl   <= r1_rl;
            r2_du   <= r1_du;
            r2_ce   <= r1_ce;
            r2_lr   <= r1_lr;
            r2_ud   <= r1_ud;
            r2_dru  <= r1_dru;
            r2_dlu  <= r1_dlu;

            r3.ax  <= w_ax[16 +: AXW];
            r3.ay  <= w_ay[16 +: AXW];
            r3.lap <= w_lap[LW-1:0];
            r3.ce  <= r2_ce;
            r3.lr  <= r2_lr;
            r3.ud  <= r2_ud;
            r3.dru <= r2_dru;
            r3.dlu <= r2_dlu;
        end
    end

    assign o_valid = r_v[3];
    assign o_ent   = r3;

endmodule

@@ sv/gcs_queue.sv @@
// gcs_queue: short flop queue that decouples the front from the back
// depends on gcs_pkg
module gcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcs_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output gcs_pkg::t_qent  o_ent,
    output gcs_pkg::t_qstat o_stat
);
    import gcs_pkg::*;

    t_qent            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_CW-1:0]  r_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_ent  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + Q_CW'(w_push) - Q_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || !w_push))
        else $error("queue push while full");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + Q_CW'($past(w_push))
                                       - Q_CW'($past(w_pop)))
        else $error("queue fill count lost track");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stat.full && !o_stat.empty) |-> r_wr != r_rd)
        else $error("queue pointers meet with entries in flight");

endmodule

@@ sv/gcs_back.sv @@
// gcs_back: magnitude root, normalising divides, directional curvature, output
// depends on gcs_pkg
module gcs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gcs_pkg::t_qent                   i_ent,
    input  logic                             i_avail,
    output logic                             o_pop,
    input  logic [gcs_pkg::THR_W-1:0]        i_thr,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic signed [gcs_pkg::OUT_W-1:0] o_curvature,
    output logic signed [gcs_pkg::OUT_W-1:0] o_gradient_out,
    output logic                             o_anisotropic
);
    import gcs_pkg::*;

    localparam int UXW      = AXW - 1;
    localparam int SQW      = 2 * UXW + 1;
    localparam int RADW     = SQW + 1;
    localparam int SQ_STEPS = RADW / 2;
    localparam int RT_W     = SQ_STEPS;
    localparam int NORM     = 23;
    localparam int SHMAX    = (UXW > NORM) ? UXW - NORM : 0;
    localparam int SHW      = $clog2(SHMAX + 2);
    localparam int NW       = 2 * NORM + 1;
    localparam int QW       = INNER_BITS + 1;
    localparam int ZW       = QW + 1;
    localparam int CW       = INNER_BITS + 3;
    localparam int PRW      = CW + SW;
    localparam int CVW      = PRW + 3 - INNER_BITS;
    localparam int L_SQ0    = 2;
    localparam int L_SQEND  = L_SQ0 + SQ_STEPS - 1;
    localparam int L_DIV0   = 3;
    localparam int L_COEF   = L_DIV0 + QW;
    localparam int L_PROD   = L_COEF + 1;
    localparam int L_CURV   = L_COEF + 2;
    localparam int NB       = ((L_CURV > L_SQEND) ? L_CURV : L_SQEND) + 1;
    localparam int CMPW     = (RT_W > THR_W + SHIFT) ? RT_W : THR_W + SHIFT;
    localparam logic signed [CVW-1:0] OUT_MAX = CVW'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [CVW-1:0] OUT_MIN = -(CVW'(1) <<< (OUT_W - 1));
    localparam logic signed [CW-1:0]  TWO_Q16 = CW'(2) <<< INNER_BITS;

    typedef struct packed {
        logic signed [AXW-1:0] ax;
        logic signed [AXW-1:0] ay;
        logic signed [LW-1:0]  lap;
        logic signed [SW-1:0]  ce;
        logic signed [SW-1:0]  lr;
        logic signed [SW-1:0]  ud;
        logic signed [SW-1:0]  dru;
        logic signed [SW-1:0]  dlu;
        logic                  zero;
        logic                  zneg;
        logic [RADW-1:0]       rad;
        logic [RT_W+1:0]       rem;
        logic [RT_W-1:0]       root;
        logic [NORM-1:0]       uxs;
        logic [NORM-1:0]       uys;
        logic [NW-1:0]         n;
        logic [NW:0]           rx;
        logic [NW:0]           ry;
        logic [NW:0]           rz;
        logic [QW-1:0]         qx;
        logic [QW-1:0]         qy;
        logic [QW-1:0]         qz;
        logic signed [ZW-1:0]  zs;
        logic signed [CW-1:0]  li;
        logic signed [CW-1:0]  l1;
        logic signed [CW-1:0]  l2;
        logic signed [PRW-1:0] p0;
        logic signed [PRW-1:0] p1;
        logic signed [PRW-1:0] p2;
        logic signed [PRW-1:0] p3;
        logic signed [PRW-1:0] p4;
        logic signed [CVW-1:0] curva;
    } t_bs;

    function automatic logic signed [OUT_W-1:0] f_to_out(input logic signed [CVW-1:0] x);
        logic signed [CVW-1:0] v;
        v = x >>> SHIFT;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic void f_div_step(input logic [NW:0] r, input logic [QW-1:0] q,
                                       input logic [NW-1:0] n,
                                       output logic [NW:0] r_o, output logic [QW-1:0] q_o);
        logic ge;
        logic [NW:0] d;
        ge  = (r >= {1'b0, n});
        d   = ge ? r - {1'b0, n} : r;
        r_o = {d[NW-1:0], 1'b0};
        q_o = {q[QW-2:0], ge};
    endfunction

    t_bs  r_bs [NB];
    t_bs  n_bs [NB];
    logic [NB-1:0] r_bv;
    logic w_en;

    logic r_ovalid;
    logic signed [OUT_W-1:0] r_curv, r_grad;
    logic r_aniso;

    logic [UXW-1:0]        w_ux, w_uy, w_m;
    logic [SHW-1:0]        w_sh;
    logic [RT_W+3:0]       w_cand, w_sub;
    logic [NW-1:0]         w_xx, w_yy, w_xy;
    logic signed [2*ZW-1:0] w_zz, w_yd, w_xd;
    logic signed [ZW-1:0]  w_x, w_y;
    logic signed [CW-1:0]  w_l0, w_l3, w_l4;
    logic signed [PRW+2:0] w_acc;

    logic [CMPW-1:0]       w_gr, w_th;
    logic                  w_aniso;
    logic signed [CVW-1:0] w_cv;
    logic signed [OUT_W-1:0] w_cout;
    t_bs                   w_f;

    // signed z from its magnitude and the sign of ax*ay
    function automatic logic signed [ZW-1:0] n_zs();
        logic signed [ZW-1:0] z;
        z = $signed({1'b0, r_bs[L_COEF-1].qz});
        return r_bs[L_COEF-1].zneg ? -z : z;
    endfunction

    // output register frees the pipeline whenever it can be taken
    assign w_en  = !r_ovalid || !i_stall;
    assign o_pop = w_en && i_avail;

    always_comb begin
        n_bs[0]     = '0;
        n_bs[0].ax  = i_ent.ax;
        n_bs[0].ay  = i_ent.ay;
        n_bs[0].lap = i_ent.lap;
        n_bs[0].ce  = i_ent.ce;
        n_bs[0].lr  = i_ent.lr;
        n_bs[0].ud  = i_ent.ud;
        n_bs[0].dru = i_ent.dru;
        n_bs[0].dlu = i_ent.dlu;

        w_ux   = UXW'(r_bs[0].ax < 0 ? -r_bs[0].ax : r_bs[0].ax);
        w_uy   = UXW'(r_bs[0].ay < 0 ? -r_bs[0].ay : r_bs[0].ay);
        w_m    = (w_ux > w_uy) ? w_ux : w_uy;
        w_sh   = '0;
        for (int i = 0; i < SHMAX; i++) begin
            if (|(w_m >> (NORM + i))) begin
                w_sh = SHW'(i + 1);
            end
        end
        w_xx = NW'(r_bs[1].uxs) * NW'(r_bs[1].uxs);
        w_yy = NW'(r_bs[1].uys) * NW'(r_bs[1].uys);
        w_xy = NW'(r_bs[1].uxs) * NW'(r_bs[1].uys);

        w_x  = $signed({1'b0, r_bs[L_COEF-1].qx});
        w_y  = $signed({1'b0, r_bs[L_COEF-1].qy});
        w_zz = (2 * ZW)'(n_zs()) * (2 * ZW)'(n_zs());
        w_yd = (2 * ZW)'(w_y) * (2 * ZW)'(w_y - w_x);
        w_xd = (2 * ZW)'(w_x) * (2 * ZW)'(w_x - w_y);

        w_l0 = (r_bs[L_PROD-1].li <<< 2) - TWO_Q16;
        w_l3 = r_bs[L_PROD-1].li - CW'(r_bs[L_PROD-1].zs >>> 1);
        w_l4 = w_l3 + CW'(r_bs[L_PROD-1].zs);

        w_acc = (PRW + 3)'(r_bs[L_CURV-1].p0) + (PRW + 3)'(r_bs[L_CURV-1].p1)
              + (PRW + 3)'(r_bs[L_CURV-1].p2) + (PRW + 3)'(r_bs[L_CURV-1].p3)
              + (PRW + 3)'(r_bs[L_CURV-1].p4);

        w_cand = '0;
        w_sub  = '0;

        for (int l = 1; l < NB; l++) begin
            n_bs[l] = r_bs[l-1];
            if (l == 1) begin
                n_bs[l].rad  = RADW'(SQW'(w_ux) * SQW'(w_ux) + SQW'(w_uy) * SQW'(w_uy));
                n_bs[l].rem  = '0;
                n_bs[l].root = '0;
                n_bs[l].uxs  = NORM'(w_ux >> w_sh);
                n_bs[l].uys  = NORM'(w_uy >> w_sh);
                n_bs[l].zero = (r_bs[0].ax == 0) && (r_bs[0].ay == 0);
                n_bs[l].zneg = r_bs[0].ax[AXW-1] ^ r_bs[0].ay[AXW-1];
            end
            // one root bit per stage, restoring
            if (l >= L_SQ0 && l <= L_SQEND) begin
                w_cand = {r_bs[l-1].rem, r_bs[l-1].rad[RADW-1:RADW-2]};
                w_sub  = (RT_W + 4)'({r_bs[l-1].root, 2'b01});
                if (w_cand >= w_sub) begin
                    n_bs[l].rem  = (RT_W + 2)'(w_cand - w_sub);
                    n_bs[l].root = {r_bs[l-1].root[RT_W-2:0], 1'b1};
                end else begin
                    n_bs[l].rem  = (RT_W + 2)'(w_cand);
                    n_bs[l].root = {r_bs[l-1].root[RT_W-2:0], 1'b0};
                end
                n_bs[l].rad = r_bs[l-1].rad << 2;
            end
            if (l == L_SQ0) begin
                n_bs[l].n  = w_xx + w_yy;
                n_bs[l].rx = (NW + 1)'(w_xx);
                n_bs[l].ry = (NW + 1)'(w_yy);
                n_bs[l].rz = (NW + 1)'(w_xy);
                n_bs[l].qx = '0;
                n_bs[l].qy = '0;
                n_bs[l].qz = '0;
            end
            // one quotient bit per stage for each of the three ratios
            if (l >= L_DIV0 && l < L_COEF) begin
                f_div_step(r_bs[l-1].rx, r_bs[l-1].qx, r_bs[l-1].n, n_bs[l].rx, n_bs[l].qx);
                f_div_step(r_bs[l-1].ry, r_bs[l-1].qy, r_bs[l-1].n, n_bs[l].ry, n_bs[l].qy);
                f_div_step(r_bs[l-1].rz, r_bs[l-1].qz, r_bs[l-1].n, n_bs[l].rz, n_bs[l].qz);
            end
            if (l == L_COEF) begin
                n_bs[l].zs = n_zs();
                n_bs[l].li = w_zz[INNER_BITS +: CW];
                n_bs[l].l1 = w_yd[INNER_BITS +: CW];
                n_bs[l].l2 = w_xd[INNER_BITS +: CW];
            end
            if (l == L_PROD) begin
                n_bs[l].p0 = PRW'(w_l0) * PRW'(r_bs[l-1].ce);
                n_bs[l].p1 = PRW'(r_bs[l-1].l1) * PRW'(r_bs[l-1].lr);
                n_bs[l].p2 = PRW'(r_bs[l-1].l2) * PRW'(r_bs[l-1].ud);
                n_bs[l].p3 = PRW'(w_l3) * PRW'(r_bs[l-1].dru);
                n_bs[l].p4 = PRW'(w_l4) * PRW'(r_bs[l-1].dlu);
            end
            if (l == L_CURV) begin
                n_bs[l].curva = w_acc[INNER_BITS +: CVW];
            end
        end
    end

    // final choice between isotropic and directional results
    always_comb begin
        w_f     = r_bs[NB-1];
        w_gr    = CMPW'(w_f.root);
        w_th    = CMPW'(i_thr) << SHIFT;
        w_aniso = !((w_gr < w_th) || w_f.zero);
        w_cv    = w_aniso ? w_f.curva : CVW'(w_f.lap);
        w_cout  = f_to_out(w_cv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= '0;
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_bv     <= {r_bv[NB-2:0], o_pop};
            r_ovalid <= r_bv[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < NB; l++) begin
                r_bs[l] <= n_bs[l];
            end
            r_curv  <= w_cout;
            r_grad  <= w_aniso ? f_to_out(CVW'({1'b0, w_f.root})) : w_cout;
            r_aniso <= w_aniso;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_curvature    = r_curv;
    assign o_gradient_out = r_grad;
    assign o_anisotropic  = r_aniso;

    a_iso_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_aniso) |-> r_curv == r_grad)
        else $error("isotropic result without curvature copy");

endmodule

@@ sv/gradient_curvature_stencil.sv @@
// gradient_curvature_stencil: top level, configuration port and the three parts
// depends on gcs_pkg, gcs_front, gcs_queue, gcs_back
// one request per cycle while the queue has room; o_stall is raised while it is full
// the back pipeline depth is set by its 28-stage magnitude root
// synchronous active-low reset clears valids, queue and threshold (256)
module gradient_curvature_stencil (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_up_left,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_up,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_up_right,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_left,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_center,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_right,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_down_left,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_down,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix_down_right,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [gcs_pkg::OUT_W-1:0] o_curvature,
    output logic signed [gcs_pkg::OUT_W-1:0] o_gradient_out,
    output logic                             o_anisotropic,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import gcs_pkg::*;

    // threshold register, written on the access phase of an apb write
    logic [THR_W-1:0] r_thr;
    logic [1:0]       w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign prdata = (w_idx == REG_GRAD_THRESHOLD) ? {16'b0, r_thr} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && (w_idx == REG_GRAD_THRESHOLD)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // window gathered into one array in raster order
    logic signed [PIX_W-1:0] w_pix [NUM_PIX];

    assign w_pix[0] = i_pix_up_left;
    assign w_pix[1] = i_pix_up;
    assign w_pix[2] = i_pix_up_right;
    assign w_pix[3] = i_pix_left;
    assign w_pix[4] = i_pix_center;
    assign w_pix[5] = i_pix_right;
    assign w_pix[6] = i_pix_down_left;
    assign w_pix[7] = i_pix_down;
    assign w_pix[8] = i_pix_down_right;

    t_qent  w_fent, w_qent;
    t_qstat w_qstat;
    logic   w_fvalid;
    logic   w_pop;
    logic   w_fen;

    // front runs as long as the queue has room, independent of the back
    assign w_fen   = !w_qstat.full;
    assign o_stall = w_qstat.full;

    gcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fen),
        .i_valid (i_valid),
        .i_pix   (w_pix),
        .o_valid (w_fvalid),
        .o_ent   (w_fent)
    );

    // four entries so the front keeps accepting while a result waits
    gcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fvalid && w_fen),
        .i_ent   (w_fent),
        .i_pop   (w_pop),
        .o_ent   (w_qent),
        .o_stat  (w_qstat)
    );

    // back pipeline halts only while the output register is held
    gcs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ent          (w_qent),
        .i_avail        (!w_qstat.empty),
        .o_pop          (w_pop),
        .i_thr          (r_thr),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_curvature    (o_curvature),
        .o_gradient_out (o_gradient_out),
        .o_anisotropic  (o_anisotropic)
    );

endmodule

@@ tb/gcs_checker.sv @@
// gcs_checker: watches both channels of the curvature stencil, predicts each result
// and compares it field by field; depends on gcs_pkg
module gcs_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_stall_in,
    input  logic signed [gcs_pkg::PIX_W-1:0] i_pix [gcs_pkg::NUM_PIX],
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [gcs_pkg::OUT_W-1:0] i_curvature,
    input  logic signed [gcs_pkg::OUT_W-1:0] i_gradient_out,
    input  logic                             i_anisotropic,
    input  logic [gcs_pkg::THR_W-1:0]        i_threshold,
    output int                               o_errors,
    output int                               o_pending
);
    import gcs_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] curv;
        logic signed [OUT_W-1:0] grad;
        logic                    aniso;
    } t_curv_res;

    t_curv_res curv_expected [$];
    int err_count = 0;
    int pend_count = 0;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(longint q16);
        longint v;
        v = floor_shift(q16, SHIFT);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[OUT_W-1:0];
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic t_curv_res predict_curvature(
        logic signed [PIX_W-1:0] px [NUM_PIX], logic [THR_W-1:0] thr);
        longint p [NUM_PIX];
        longint c1, d1, ax, ay, ux, uy, grad, s, m, n, xx, yy, zz;
        longint li, l0, l1, l2, l3, l4, acc;
        t_curv_res r;
        for (int i = 0; i < NUM_PIX; i++) p[i] = longint'(px[i]) * (1 << SHIFT);
        c1 = p[8] - p[0];
        d1 = p[6] - p[2];
        ax = floor_shift(19195 * ((p[5] - p[3]) + floor_shift(92682 * (c1 - d1), 16)), 16);
        ay = floor_shift(19195 * ((p[7] - p[1]) + floor_shift(92682 * (c1 + d1), 16)), 16);
        ux = ax < 0 ? -ax : ax;
        uy = ay < 0 ? -ay : ay;
        grad = root_floor(ux * ux + uy * uy);
        if (grad < longint'(thr) * (1 << SHIFT) || (ux == 0 && uy == 0)) begin
            s = (p[0] + p[2] + p[6] + p[8]) + 2 * (p[1] + p[3] + p[5] + p[7]) - 12 * p[4];
            s = s >= 0 ? s / 12 : -((-s + 11) / 12);
            r.curv = sat_out(s);
            r.grad = r.curv;
            r.aniso = 1'b0;
            return r;
        end
        m = ux > uy ? ux : uy;
        while (m >= (64'sd1 << 23)) begin
            ux >>= 1;
            uy >>= 1;
            m >>= 1;
        end
        n = ux * ux + uy * uy;
        xx = ((ux * ux) << 16) / n;
        yy = ((uy * uy) << 16) / n;
        zz = ((ux * uy) << 16) / n;
        if ((ax < 0) != (ay < 0)) zz = -zz;
        li = floor_shift(zz * zz, 16);
        l0 = -(64'sd2 << 16) + 4 * li;
        l1 = floor_shift(yy * (yy - xx), 16);
        l2 = floor_shift(xx * (xx - yy), 16);
        l3 = li - floor_shift(zz, 1);
        l4 = l3 + zz;
        acc = l0 * p[4] + l1 * (p[3] + p[5]) + l2 * (p[1] + p[7])
            + l3 * (p[8] + p[0]) + l4 * (p[6] + p[2]);
        r.curv = sat_out(floor_shift(acc, 16));
        r.grad = sat_out(grad);
        r.aniso = 1'b1;
        return r;
    endfunction

    assign o_pending = pend_count;
    assign o_errors  = err_count;

    always @(posedge i_clk) begin
        t_curv_res e;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                curv_expected.push_back(predict_curvature(i_pix, i_threshold));
            if (i_out_valid && !i_out_stall) begin
                if (curv_expected.size() == 0) begin
                    $error("unexpected result");
                    err_count++;
                end else begin
                    e = curv_expected.pop_front();
                    if (e.curv !== i_curvature) begin
                        $error("curvature exp %0d got %0d", e.curv, i_curvature);
                        err_count++;
                    end
                    if (e.grad !== i_gradient_out) begin
                        $error("gradient_out exp %0d got %0d", e.grad, i_gradient_out);
                        err_count++;
                    end
                    if (e.aniso !== i_anisotropic) begin
                        $error("anisotropic exp %0b got %0b", e.aniso, i_anisotropic);
                        err_count++;
                    end
                end
            end
            pend_count = curv_expected.size();
        end
    end
endmodule

@@ tb/tb_gradient_curvature_stencil.sv @@
// tb_gradient_curvature_stencil: stimulus and verdict for the curvature stencil
// depends on gcs_pkg, gradient_curvature_stencil and gcs_checker
module tb_gradient_curvature_stencil;
    import gcs_pkg::*;

    localparam int LATENCY = 35;
    localparam int HOLD_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PIX_W-1:0] pix [NUM_PIX];
    logic signed [OUT_W-1:0] curvature, gradient_out;
    logic anisotropic;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    // threshold as last written, seen by the checker
    logic [THR_W-1:0] thr_model = THR_RESET;
    int errors, pending;
    // stall shaping
    bit quiet_tail = 0;
    bit hold_long = 0;
    int hold_cnt = 0;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    initial for (int i = 0; i < NUM_PIX; i++) pix[i] = '0;

    gradient_curvature_stencil u_dut (
        .i_clk, .i_rst_n,
        .i_valid(in_valid), .o_stall(in_stall),
        .i_pix_up_left(pix[0]), .i_pix_up(pix[1]), .i_pix_up_right(pix[2]),
        .i_pix_left(pix[3]), .i_pix_center(pix[4]), .i_pix_right(pix[5]),
        .i_pix_down_left(pix[6]), .i_pix_down(pix[7]), .i_pix_down_right(pix[8]),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_curvature(curvature), .o_gradient_out(gradient_out),
        .o_anisotropic(anisotropic),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    gcs_checker u_checker (
        .i_clk, .i_rst_n,
        .i_valid(in_valid), .i_stall_in(in_stall), .i_pix(pix),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_curvature(curvature), .i_gradient_out(gradient_out),
        .i_anisotropic(anisotropic), .i_threshold(thr_model),
        .o_errors(errors), .o_pending(pending)
    );

    // apb write: setup then access
    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4 * REG_GRAD_THRESHOLD);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr_model <= v;
    endtask

    // let everything drain before touching the register
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // one request, held until accepted; optional sender gap first
    task automatic send_window(logic signed [PIX_W-1:0] w [NUM_PIX], bit gaps);
        if (gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < NUM_PIX; i++) pix[i] <= w[i];
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // random window: smooth ramp plus noise, random extremes, or raw bit noise
    task automatic random_window(output logic signed [PIX_W-1:0] w [NUM_PIX]);
        int kind, base, gx, gy, amp;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 262143) - 131072;
        gx = $urandom_range(0, 2048) - 1024;
        gy = $urandom_range(0, 2048) - 1024;
        amp = 1 << $urandom_range(0, 12);
        for (int i = 0; i < NUM_PIX; i++) begin
            if (kind < 3)
                w[i] = PIX_W'($urandom);
            else if (kind == 3)
                w[i] = $urandom_range(0, 1) ? 18'sh1ffff : 18'sh20000;
            else begin
                int v;
                v = (base / 2) + gx * (i % 3 - 1) + gy * (i / 3 - 1)
                    + int'($urandom_range(0, 2 * amp)) - amp;
                if (v > 131071) v = 131071;
                if (v < -131072) v = -131072;
                w[i] = v[PIX_W-1:0];
            end
        end
    endtask

    // receiver stalls in random bursts, or one long counted hold
    always @(posedge i_clk) begin
        if (hold_long && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            out_stall <= 1'b1;
        end else if (quiet_tail) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        logic signed [PIX_W-1:0] w [NUM_PIX];
        logic [THR_W-1:0] thr_set [4];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flat, extremes, alternating, centre spikes, single pixels, ramps, an edge
        for (int d = 0; d < 22; d++) begin
            for (int i = 0; i < NUM_PIX; i++) begin
                case (d)
                    0: w[i] = '0;
                    1: w[i] = 18'sh1ffff;
                    2: w[i] = 18'sh20000;
                    3: w[i] = (i % 2) ? 18'sh1ffff : 18'sh20000;
                    4: w[i] = (i % 2) ? 18'sh20000 : 18'sh1ffff;
                    5: w[i] = (i == 4) ? 18'sh1ffff : 18'sh20000;
                    6: w[i] = (i == 4) ? 18'sh20000 : 18'sh1ffff;
                    default: w[i] = (i == d - 7 || i == (d - 7) % 9) ? 18'sh00100 : '0;
                endcase
                if (d == 16) w[i] = PIX_W'(((i % 3) - 1) * 64);
                if (d == 17) w[i] = PIX_W'(((i / 3) - 1) * 64);
                if (d == 18) w[i] = PIX_W'(((i % 3) + (i / 3)) * 4000);
                if (d == 19) w[i] = PIX_W'(((i % 3) - (i / 3)) * 1);
                if (d == 20) w[i] = PIX_W'(i * 30000);
                if (d == 21) w[i] = (i % 3 == 2) ? 18'sh1ffff : 18'sh20000;
            end
            send_window(w, 0);
        end
        stop_sending();
        wait_idle();

        // random phases over several thresholds, zero and max among them
        thr_set = '{16'd0, 16'd65535, 16'd3, 16'd256};
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(ph == 3 ? 16'($urandom_range(0, 65535)) : thr_set[ph]);
            for (int k = 0; k < 200; k++) begin
                random_window(w);
                send_window(w, 1);
                if (ph == 1 && k == 50) begin
                    // receiver holds off while the sender keeps offering
                    hold_long = 1;
                    for (int c = 0; c < 80; c++) begin
                        random_window(w);
                        send_window(w, 0);
                    end
                    hold_long = 0;
                end
                if (ph == 2 && k == 100) begin
                    // sender pauses until everything has drained
                    stop_sending();
                    while (pending != 0) @(posedge i_clk);
                end
            end
            stop_sending();
            wait_idle();
        end

        // last part with no idling on either side
        quiet_tail = 1;
        write_threshold(16'd256);
        for (int k = 0; k < 100; k++) begin
            random_window(w);
            send_window(w, 0);
        end
        stop_sending();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
